[hw/rtl/ucd_pkg.sv]
package ucd_pkg;

    // One raw byte of the string as it arrives on the request channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    // One decoded code point as it leaves on the result channel.
    typedef struct packed {
        logic [20:0] code_point;
        logic        last_point;
        logic        truncated;
    } t_out_item;

    // What the front end decided a byte is.
    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_LEAD,
        KIND_CONT
    } t_kind;

    // Classified byte passed from the front end to the back end.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] data;
        logic [1:0]  need;
        logic        eos;
    } t_cmd;

    localparam int unsigned CMD_W = $bits(t_cmd);
    localparam int unsigned OUT_W = $bits(t_out_item);

    localparam logic [7:0]  LEAD_MIN    = 8'hC0;
    localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
    localparam logic [7:0]  CONT_MIN    = 8'h80;
    localparam logic [7:0]  MASK_LEAD2  = 8'h1F;
    localparam logic [7:0]  MASK_LEAD3  = 8'h0F;
    localparam logic [7:0]  MASK_LEAD4  = 8'h07;
    localparam logic [5:0]  MASK_CONT   = 6'h3F;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] UPPER_A     = 21'h41;
    localparam logic [20:0] UPPER_Z     = 21'h5A;
    localparam logic [20:0] CASE_OFFSET = 21'd32;

endpackage

[hw/rtl/ucd_front.sv]
module ucd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  ucd_pkg::t_in_item i_item,
    output ucd_pkg::t_cmd   o_cmd
);
    import ucd_pkg::*;

    // Continuation bytes still expected, tracked here so that each byte can be
    // classified as it is accepted.
    logic [1:0] r_pending;
    logic [1:0] n_pending;
    t_cmd       cmd;

    always_comb begin
        cmd      = '0;
        cmd.eos  = i_item.end_of_string;
        cmd.kind = KIND_CHAR;
        n_pending = r_pending;
        if (r_pending != 2'd0) begin
            cmd.kind  = KIND_CONT;
            cmd.data  = {10'd0, i_item.data_byte[5:0]};
            n_pending = i_item.end_of_string ? 2'd0 : r_pending - 2'd1;
        end else if (i_item.data_byte < CONT_MIN) begin
            cmd.data = {8'd0, i_item.data_byte};
        end else if (i_item.data_byte < LEAD_MIN) begin
            cmd.data = REPLACEMENT;
        end else begin
            cmd.kind = KIND_LEAD;
            if (i_item.data_byte < LEAD3_MIN) begin
                cmd.need = 2'd1;
                cmd.data = {8'd0, i_item.data_byte & MASK_LEAD2};
            end else if (i_item.data_byte < LEAD4_MIN) begin
                cmd.need = 2'd2;
                cmd.data = {8'd0, i_item.data_byte & MASK_LEAD3};
            end else begin
                cmd.need = 2'd3;
                cmd.data = {8'd0, i_item.data_byte & MASK_LEAD4};
            end
            n_pending = i_item.end_of_string ? 2'd0 : cmd.need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else if (i_accept) begin
            r_pending <= n_pending;
        end
    end

    assign o_cmd = cmd;

endmodule

[hw/rtl/ucd_queue.sv]
module ucd_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + AW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/ucd_back.sv]
module ucd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  logic              i_cmd_valid,
    input  ucd_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output ucd_pkg::t_out_item o_res
);
    import ucd_pkg::*;

    logic        r_fold;
    logic [1:0]  r_pend;
    logic [4:0]  r_lead;
    logic [20:0] r_acc;
    logic [1:0]  n_pend;
    logic [4:0]  n_lead;
    logic [20:0] n_acc;
    logic        take;
    logic        emit;
    t_out_item   res;
    logic [20:0] cont_acc;
    logic [1:0]  cont_pend;

    assign take      = i_cmd_valid && !i_res_full;
    assign cont_acc  = {r_acc[14:0], i_cmd.data[5:0] & MASK_CONT};
    assign cont_pend = r_pend - 2'd1;

    always_comb begin
        n_pend = r_pend;
        n_lead = r_lead;
        n_acc  = r_acc;
        emit   = 1'b0;
        res    = '0;
        unique case (i_cmd.kind)
            KIND_CHAR: begin
                emit           = 1'b1;
                res.code_point = {5'd0, i_cmd.data};
                res.last_point = i_cmd.eos;
            end
            KIND_LEAD: begin
                if (i_cmd.eos) begin
                    emit           = 1'b1;
                    res.code_point = {16'd0, i_cmd.data[4:0]};
                    res.last_point = 1'b1;
                    res.truncated  = 1'b1;
                end else begin
                    n_pend = i_cmd.need;
                    n_lead = i_cmd.data[4:0];
                    n_acc  = {16'd0, i_cmd.data[4:0]};
                end
            end
            KIND_CONT: begin
                n_pend = cont_pend;
                n_acc  = cont_acc;
                if (cont_pend == 2'd0) begin
                    emit           = 1'b1;
                    res.code_point = cont_acc;
                    res.last_point = i_cmd.eos;
                end else if (i_cmd.eos) begin
                    emit           = 1'b1;
                    res.code_point = {16'd0, r_lead};
                    res.last_point = 1'b1;
                    res.truncated  = 1'b1;
                    n_pend         = 2'd0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        // Optional ASCII lower-casing on every emitted value.
        if (r_fold && res.code_point >= UPPER_A && res.code_point <= UPPER_Z) begin
            res.code_point = res.code_point + CASE_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= 1'b0;
            r_pend <= 2'd0;
            r_lead <= 5'd0;
            r_acc  <= 21'd0;
        end else begin
            if (i_cfg_valid) begin
                r_fold <= i_cfg_data;
            end
            if (take) begin
                r_pend <= n_pend;
                r_lead <= n_lead;
                r_acc  <= n_acc;
            end
        end
    end

    assign o_cmd_pop  = take;
    assign o_res_push = take && emit;
    assign o_res      = res;

endmodule

[hw/rtl/utf8_codepoint_decoder.sv]
// Lenient UTF-8 decoder: bytes of a string go in, code points come out.
// Request channel: the producer drives i_in_item and raises push; a byte is
// taken at a rising edge where push is high and full is low. The last byte of
// a string carries end_of_string, and it always yields exactly one result with
// last_point set, truncated too if the string ended inside a sequence.
// Result channel: while empty is low the oldest code point sits on
// o_out_item, and it is taken at a rising edge where pop is high.
// Configuration: the user writes fold_case through i_cfg_valid/i_cfg_data only
// while the decoder is idle; the block does not enforce it. o_cfg_ready is
// always high. Throughput is one byte per cycle while full is low. The final
// byte of a code point is written into the command queue; the back end decodes
// it from there and writes the result to the result queue, from which it shows
// on the ports.
// If the consumer stalls, the result queue fills, the back end stops draining
// the command queue and full rises once that queue is also full; no request is
// lost. After the synchronous reset both queues are empty, no sequence is open
// and fold_case is cleared.
module utf8_codepoint_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ucd_pkg::t_in_item  i_in_item,
    input  logic               pop,
    output logic               empty,
    output ucd_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import ucd_pkg::*;

    logic            in_accept;
    t_cmd            front_cmd;
    logic [CMD_W-1:0] cmd_bits;
    t_cmd            back_cmd;
    logic            cmd_empty;
    logic            cmd_pop;
    logic            res_full;
    logic            res_push;
    t_out_item       res;
    logic [OUT_W-1:0] out_bits;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    // Front end: classifies each byte as it is taken, tracking how many
    // continuation bytes the open sequence still needs.
    ucd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_cmd    (front_cmd)
    );

    // Command queue decouples the front end from the decode back end.
    ucd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (cmd_empty)
    );

    assign back_cmd = t_cmd'(cmd_bits);

    // Back end: builds the code point, handles truncation and case folding.
    ucd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Result queue holds finished code points until the consumer pops them.
    ucd_queue #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_bits),
        .o_empty (empty)
    );

    assign o_out_item = t_out_item'(out_bits);

endmodule

[tb/codepoint_board_pkg.sv]
package codepoint_board_pkg;

    import ucd_pkg::*;

    // Tracks the decoder's sequence state and keeps the code points still to come.
    class codepoint_board;
        bit        fold_case;
        bit [1:0]  bytes_left;
        bit [4:0]  lead_bits;
        bit [20:0] partial_point;
        t_out_item due_points[$];
        int        mismatches;

        function void set_fold(bit value);
            fold_case = value;
        endfunction

        function void clear_sequence();
            bytes_left    = '0;
            lead_bits     = '0;
            partial_point = '0;
        endfunction

        function void expect_point(logic [20:0] value, logic last, logic cut);
            t_out_item point;
            if (fold_case && value >= UPPER_A && value <= UPPER_Z) begin
                value = value + CASE_OFFSET;
            end
            point.code_point = value;
            point.last_point = last;
            point.truncated  = cut;
            due_points = {due_points, point};
        endfunction

        function void note_byte(t_in_item item);
            logic [7:0] value;
            logic       eos;
            value = item.data_byte;
            eos   = item.end_of_string;
            if (bytes_left != 2'd0) begin
                partial_point = {partial_point[14:0], value[5:0]};
                bytes_left    = bytes_left - 2'd1;
                if (bytes_left == 2'd0) begin
                    expect_point(partial_point, eos, 1'b0);
                    clear_sequence();
                end else if (eos) begin
                    expect_point(21'(lead_bits), 1'b1, 1'b1);
                    clear_sequence();
                end
            end else if (value < CONT_MIN) begin
                expect_point(21'(value), eos, 1'b0);
            end else if (value < LEAD_MIN) begin
                expect_point(21'(REPLACEMENT), eos, 1'b0);
            end else begin
                if (value < LEAD3_MIN) begin
                    bytes_left = 2'd1;
                    lead_bits  = 5'(value & MASK_LEAD2);
                end else if (value < LEAD4_MIN) begin
                    bytes_left = 2'd2;
                    lead_bits  = 5'(value & MASK_LEAD3);
                end else begin
                    bytes_left = 2'd3;
                    lead_bits  = 5'(value & MASK_LEAD4);
                end
                partial_point = 21'(lead_bits);
                if (eos) begin
                    expect_point(21'(lead_bits), 1'b1, 1'b1);
                    clear_sequence();
                end
            end
        endfunction

        function void check_point(t_out_item got);
            t_out_item want;
            if (due_points.size() == 0) begin
                mismatches++;
                $display("%0t: code point %h with none expected", $time, got.code_point);
                return;
            end
            want = due_points.pop_front();
            if (got !== want) begin
                mismatches++;
                if (got.code_point !== want.code_point) begin
                    $display("%0t: code_point expected %h actual %h",
                             $time, want.code_point, got.code_point);
                end
                if (got.last_point !== want.last_point) begin
                    $display("%0t: last_point expected %b actual %b",
                             $time, want.last_point, got.last_point);
                end
                if (got.truncated !== want.truncated) begin
                    $display("%0t: truncated expected %b actual %b",
                             $time, want.truncated, got.truncated);
                end
            end
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ucd_pkg::*;
    import codepoint_board_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      pop;
    logic      empty;
    t_out_item o_out_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;

    codepoint_board board;

    // Random idling on both sides is switched off for the last phase.
    bit idle_bursts;
    // Asks the result side to hold off for a long stretch.
    bit hold_request;
    int bytes_sent;

    // Directed string: bit 8 is end_of_string, the low byte is the data. It walks
    // through plain bytes at both ends and the letter range, stray continuation
    // bytes, the boundary leads 0xC0, 0xDF, 0xEF and 0xF0, a lead above 0xF7
    // followed by lead-like continuation bytes, a complete sequence that ends a
    // string, and strings that end inside a sequence or on a lead.
    localparam logic [8:0] DIRECTED_BYTES [25] = '{
        9'h000, 9'h07F, 9'h041, 9'h05A, 9'h080, 9'h0BF,
        9'h0C0, 9'h080, 9'h0DF, 9'h0BF,
        9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F8, 9'h0C0, 9'h0FF, 9'h0FF,
        9'h0F0, 9'h080, 9'h080, 9'h180,
        9'h0E2, 9'h182,
        9'h1C3,
        9'h1FF
    };

    // Case folding setting for each random phase; both extremes and a repeat.
    localparam bit [5:0] FOLD_PLAN  = 6'b101101;
    localparam int       PHASES     = 6;
    localparam int       PHASE_SIZE = 238;

    utf8_codepoint_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // All handshakes are observed at the rising edge. Inputs only ever change
    // at the falling edge, so the values seen here are the ones the decoder
    // sampled, and its outputs still hold their values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.set_fold(i_cfg_data);
            end
            if (push && !full) begin
                board.note_byte(i_in_item);
            end
            if (pop && !empty) begin
                board.check_point(o_out_item);
            end
        end
    end

    // Result side. Each pass of the loop waits for a falling edge and assigns pop
    // once, so pop is assigned at most once per time step. The long hold is
    // counted here in cycles while the request side keeps pushing, which fills
    // both internal queues and must raise full without losing a byte.
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                pop <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offers one byte and returns at the falling edge after it was taken.
    // It is entered at a falling edge on which push has not yet been assigned.
    task automatic send_byte(input logic [7:0] value, input logic last);
        if (idle_bursts && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        push                    <= 1'b1;
        i_in_item.data_byte     <= value;
        i_in_item.end_of_string <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Builds one string of a few code points and sends it. Most pieces are
    // well-formed characters with random payloads; the rest are stray
    // continuation bytes, arbitrary bytes and, now and then, a continuation
    // that is not one at all. Some strings are cut short inside their last
    // sequence so that they end truncated.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         pieces;
        int         kind;
        int         piece_len;
        pieces    = $urandom_range(1, 8);
        piece_len = 1;
        for (int p = 0; p < pieces; p++) begin
            kind      = $urandom_range(0, 99);
            piece_len = 1;
            if (kind < 30) begin
                // Half of the plain bytes sit around the upper case letters.
                if ($urandom_range(0, 1) == 1) begin
                    text = {text, 8'($urandom_range(8'h3F, 8'h5C))};
                end else begin
                    text = {text, 8'($urandom_range(0, 8'h7F))};
                end
            end else if (kind < 75) begin
                if (kind < 45) begin
                    piece_len = 2;
                    text = {text, 8'($urandom_range(8'hC0, 8'hDF))};
                end else if (kind < 60) begin
                    piece_len = 3;
                    text = {text, 8'($urandom_range(8'hE0, 8'hEF))};
                end else begin
                    piece_len = 4;
                    text = {text, 8'($urandom_range(8'hF0, 8'hFF))};
                end
                for (int k = 1; k < piece_len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        text = {text, 8'($urandom_range(0, 8'hFF))};
                    end else begin
                        text = {text, 8'($urandom_range(8'h80, 8'hBF))};
                    end
                end
            end else if (kind < 85) begin
                text = {text, 8'($urandom_range(8'h80, 8'hBF))};
            end else begin
                text = {text, 8'($urandom_range(0, 8'hFF))};
            end
        end
        if (piece_len > 1 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, piece_len - 1)) void'(text.pop_back());
        end
        for (int k = 0; k < text.size(); k++) begin
            send_byte(text[k], k == text.size() - 1);
        end
    endtask

    // Waits until every expected code point has come out, then lets a lead
    // that is still in the pipeline settle before anything else happens.
    task automatic wait_drained();
        while (board.due_points.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_fold(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        board        = new();
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_in_item    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 1'b0;
        idle_bursts  = 1'b1;
        hold_request = 1'b0;
        bytes_sent   = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_fold(1'b0);
        foreach (DIRECTED_BYTES[i]) begin
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            push <= 1'b0;
            wait_drained();
            write_fold(FOLD_PLAN[phase]);
            if (phase == PHASES - 1) begin
                idle_bursts = 1'b0;
            end
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            while (bytes_sent < 25 + (phase + 1) * PHASE_SIZE) begin
                send_random_string();
            end
        end

        push <= 1'b0;
        wait_drained();
        if (board.mismatches == 0 && board.due_points.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guards against a stalled handshake; far beyond the slowest correct run.
    initial begin
        #3ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
